/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge while reset is released.
`define ASSERT_CLKRST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// Checked at every rising edge, reset included.
`define ASSERT_CLK(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

/* hw/rtl/m2iq_pkg.sv */
// ----------------------------------------------------------------------------
// m2iq_pkg
// Types, constants and the intra weight table of the intra inverse quantizer.
// ----------------------------------------------------------------------------
package m2iq_pkg;

  localparam int COEF_IN_W   = 12;
  localparam int COEF_OUT_W  = 15;
  localparam int WEIGHT_W    = 7;
  localparam int DC_PREC_W   = 2;
  localparam int QSCALE_W    = 7;
  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 7;
  localparam int POS_W       = 6;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  localparam int FIFO_DEPTH_DEF = 4;

  localparam int AC_MAX = 2047;
  localparam int AC_MIN = -2048;
  localparam int AC_SHIFT = 4;

  localparam logic [POS_W-1:0] POS_LAST = POS_W'(63);

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_DC_PREC = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_QSCALE  = 1'b1;

  localparam logic [WEIGHT_W-1:0] INTRA_W [64] = '{
     7'd8, 7'd16, 7'd19, 7'd22, 7'd26, 7'd27, 7'd29, 7'd34,
    7'd16, 7'd16, 7'd22, 7'd24, 7'd27, 7'd29, 7'd34, 7'd37,
    7'd19, 7'd22, 7'd26, 7'd27, 7'd29, 7'd34, 7'd34, 7'd38,
    7'd22, 7'd22, 7'd26, 7'd27, 7'd29, 7'd34, 7'd37, 7'd40,
    7'd22, 7'd26, 7'd27, 7'd29, 7'd32, 7'd35, 7'd40, 7'd48,
    7'd26, 7'd27, 7'd29, 7'd32, 7'd35, 7'd40, 7'd48, 7'd58,
    7'd26, 7'd27, 7'd29, 7'd34, 7'd38, 7'd46, 7'd56, 7'd69,
    7'd27, 7'd29, 7'd35, 7'd38, 7'd46, 7'd56, 7'd69, 7'd83
  };

  typedef struct packed {
    logic signed [COEF_IN_W-1:0] coef;
    logic [WEIGHT_W-1:0]         weight;
    logic                        is_dc;
    logic                        is_last;
  } m2iq_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } m2iq_fifo_stat_t;

endpackage

/* hw/rtl/m2iq_front.sv */
// ----------------------------------------------------------------------------
// m2iq_front
// Accepts coefficients, tracks block position, attaches weight and kind.
// ----------------------------------------------------------------------------
module m2iq_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [m2iq_pkg::COEF_IN_W-1:0] in_coef,
  input  m2iq_pkg::m2iq_fifo_stat_t         fifo_stat,
  output logic                              push,
  output m2iq_pkg::m2iq_item_t              push_item
);
  import m2iq_pkg::*;

  logic [POS_W-1:0] position_r;
  logic [POS_W-1:0] position_nxt;

  assign in_ready = !fifo_stat.full;
  assign push     = in_valid && in_ready;

  assign push_item.coef    = in_coef;
  assign push_item.weight  = INTRA_W[position_r];
  assign push_item.is_dc   = (position_r == '0);
  assign push_item.is_last = (position_r == POS_LAST);

  assign position_nxt = push ? position_r + 1'b1 : position_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r <= '0;
    end else begin
      position_r <= position_nxt;
    end
  end

endmodule

/* hw/rtl/m2iq_fifo.sv */
// ----------------------------------------------------------------------------
// m2iq_fifo
// Small register queue between the front and back parts.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module m2iq_fifo #(
  parameter int DEPTH = m2iq_pkg::FIFO_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  m2iq_pkg::m2iq_item_t      push_item,
  input  logic                      pop,
  output m2iq_pkg::m2iq_item_t      pop_item,
  output m2iq_pkg::m2iq_fifo_stat_t stat
);
  import m2iq_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  m2iq_item_t       mem_r [DEPTH];
  logic [IDX_W-1:0] wr_ptr_r;
  logic [IDX_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push_ok;
  logic             pop_ok;

  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign push_ok    = push && !stat.full;
  assign pop_ok     = pop && !stat.empty;
  assign pop_item   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_r <= (wr_ptr_r == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr_r <= (rd_ptr_r == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop_ok && !push_ok) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  `ASSERT_CLKRST(a_cnt_bound, clk, rst_n, count_r <= CNT_W'(DEPTH))
  `ASSERT_CLKRST(a_no_pop_empty, clk, rst_n, pop |-> !stat.empty)
  `ASSERT_CLKRST(a_cnt_inc, clk, rst_n,
    (push_ok && !pop_ok) |=> (count_r == $past(count_r) + CNT_W'(1)))

endmodule

/* hw/rtl/m2iq_back.sv */
// ----------------------------------------------------------------------------
// m2iq_back
// Multiplies, shifts, clamps, tracks parity and drives the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module m2iq_back (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [m2iq_pkg::DC_PREC_W-1:0]        dc_prec,
  input  logic [m2iq_pkg::QSCALE_W-1:0]         qscale,
  input  m2iq_pkg::m2iq_fifo_stat_t             fifo_stat,
  input  m2iq_pkg::m2iq_item_t                  pop_item,
  output logic                                  pop,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [m2iq_pkg::COEF_OUT_W-1:0] out_coef,
  output logic                                  out_last
);
  import m2iq_pkg::*;

  localparam int P1_W = COEF_IN_W + WEIGHT_W + 1;
  localparam int P2_W = P1_W + QSCALE_W + 1;
  localparam int SH_W = P2_W - AC_SHIFT;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_FIN, S_OUT} state_t;

  state_t                       state_r;
  logic signed [COEF_IN_W-1:0]  coef_r;
  logic                         is_dc_r;
  logic                         is_last_r;
  logic signed [P1_W-1:0]       prod1_r;
  logic signed [P2_W-1:0]       prod2_r;
  logic                         parity_r;
  logic                         out_valid_r;
  logic signed [COEF_OUT_W-1:0] out_coef_r;
  logic                         out_last_r;

  logic signed [P1_W-1:0]       prod1_nxt;
  logic signed [P2_W-1:0]       prod2_nxt;
  logic signed [SH_W-1:0]       shifted;
  logic signed [COEF_IN_W-1:0]  ac_val;
  logic signed [COEF_OUT_W-1:0] dc_val;
  logic signed [COEF_OUT_W-1:0] val;
  logic                         parity_nxt;
  logic signed [COEF_OUT_W-1:0] out_coef_nxt;

  assign pop = (state_r == S_IDLE) && !fifo_stat.empty;

  assign prod1_nxt = P1_W'(pop_item.coef * $signed({1'b0, pop_item.weight}));
  assign prod2_nxt = P2_W'(prod1_r * $signed({1'b0, qscale}));

  always_comb begin
    shifted = SH_W'(prod2_r >>> AC_SHIFT);
    if (shifted > SH_W'(AC_MAX)) begin
      ac_val = COEF_IN_W'(AC_MAX);
    end else if (shifted < $signed(SH_W'(AC_MIN))) begin
      ac_val = COEF_IN_W'(AC_MIN);
    end else begin
      ac_val = COEF_IN_W'(shifted);
    end
    // ~dc_prec == 3 - dc_prec
    dc_val = $signed({{(COEF_OUT_W - COEF_IN_W){coef_r[COEF_IN_W-1]}}, coef_r}) <<< (~dc_prec);
    if (is_dc_r) begin
      val        = dc_val;
      parity_nxt = dc_val[0];
    end else begin
      val        = {{(COEF_OUT_W - COEF_IN_W){ac_val[COEF_IN_W-1]}}, ac_val};
      parity_nxt = parity_r ^ ac_val[0];
    end
    out_coef_nxt = val;
    // mismatch control on the last coefficient
    if (is_last_r && !parity_nxt) begin
      out_coef_nxt[0] = ~val[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      parity_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (pop) begin
            coef_r    <= pop_item.coef;
            is_dc_r   <= pop_item.is_dc;
            is_last_r <= pop_item.is_last;
            prod1_r   <= prod1_nxt;
            state_r   <= S_MUL;
          end
        end
        S_MUL: begin
          prod2_r <= prod2_nxt;
          state_r <= S_FIN;
        end
        S_FIN: begin
          parity_r    <= parity_nxt;
          out_coef_r  <= out_coef_nxt;
          out_last_r  <= is_last_r;
          out_valid_r <= 1'b1;
          state_r     <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_coef  = out_coef_r;
  assign out_last  = out_last_r;

  `ASSERT_CLKRST(a_pop_to_out, clk, rst_n, pop |-> ##3 out_valid)
  `ASSERT_CLKRST(a_valid_src, clk, rst_n, $rose(out_valid) |-> $past(state_r) == S_FIN)

endmodule

/* hw/rtl/mpeg2_intra_inverse_quant.sv */
// ----------------------------------------------------------------------------
// mpeg2_intra_inverse_quant
// MPEG-2 intra inverse quantizer with mismatch control, one coefficient a beat.
// ----------------------------------------------------------------------------
// channel  dir  handshake            payload
// cfg      in   cfg_we               cfg_addr, cfg_wdata
// in       in   in_tvalid/in_tready  in_tdata[11:0] coef_in
// out      out  out_tvalid/out_tready out_tdata[14:0] coef_out, out_tlast block_end
//
// The back part handles one coefficient at a time: pop and first multiply,
// second multiply, shift/clamp/parity, then the result beat, held until
// out_tready; the sequencer pops the next coefficient only after that.
// The front queue (FIFO_DEPTH beats) keeps taking input while a result waits.
// Synchronous active-low reset clears position, parity, queue, dc_prec; qscale to 1.
// ----------------------------------------------------------------------------
module mpeg2_intra_inverse_quant #(
  parameter int FIFO_DEPTH = m2iq_pkg::FIFO_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [m2iq_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [m2iq_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [m2iq_pkg::IN_TDATA_W-1:0]      in_tdata,   // [11:0] coef_in
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [m2iq_pkg::OUT_TDATA_W-1:0]     out_tdata,  // [14:0] coef_out
  output logic                                 out_tlast
);
  import m2iq_pkg::*;

  logic [DC_PREC_W-1:0]         dc_prec_r;
  logic [QSCALE_W-1:0]          qscale_r;
  m2iq_fifo_stat_t              fifo_stat;
  m2iq_item_t                   push_item;
  m2iq_item_t                   pop_item;
  logic                         push;
  logic                         pop;
  logic signed [COEF_OUT_W-1:0] out_coef;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dc_prec_r <= '0;
      qscale_r  <= QSCALE_W'(1);
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_DC_PREC: dc_prec_r <= cfg_wdata[DC_PREC_W-1:0];
        CFG_QSCALE:  qscale_r  <= cfg_wdata[QSCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  m2iq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_coef   ($signed(in_tdata[COEF_IN_W-1:0])),
    .fifo_stat (fifo_stat),
    .push      (push),
    .push_item (push_item)
  );

  m2iq_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .stat      (fifo_stat)
  );

  m2iq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .dc_prec   (dc_prec_r),
    .qscale    (qscale_r),
    .fifo_stat (fifo_stat),
    .pop_item  (pop_item),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_coef  (out_coef),
    .out_last  (out_tlast)
  );

  assign out_tdata = {{(OUT_TDATA_W - COEF_OUT_W){1'b0}}, out_coef};

endmodule
